// ===== rtl/lat_pkg.sv =====
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and constants for the lattice atom tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

  localparam int unsigned SITE_W = 12;
  localparam int unsigned LIM_W  = 13;
  localparam int unsigned STEP_W = 32;
  localparam int unsigned MSD_W  = 64;
  localparam int unsigned HELD_W = 13;
  localparam int unsigned CNT6_W = 6;

  localparam logic [LIM_W-1:0]  LIM_RESET = 13'd4096;
  localparam logic [CNT6_W-1:0] DIV_LAST  = 6'd63;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MOVE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MV_SCAN,
    ST_MV_SRC,
    ST_MV_CLR,
    ST_MV_SET,
    ST_Q_SCAN,
    ST_Q_INIT,
    ST_Q_DIV,
    ST_RESULT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_CAPTURE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_MV_SRC,
    CMD_MV_CLR,
    CMD_MV_SET,
    CMD_QSCAN,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    logic clr_last;
    logic total_zero;
    logic hit;
    logic scan_end;
    logic q_done;
    logic div_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [SITE_W-1:0]        site;
    logic signed [STEP_W-1:0] sx;
    logic signed [STEP_W-1:0] sy;
    logic signed [STEP_W-1:0] sz;
  } atom_t;

endpackage

`default_nettype wire

// ===== rtl/lat_ctrl.sv =====
// ----------------------------------------------------------------------------
// lat_ctrl
// Sequencer: clear after reset; load, move scan/update, query scan/divide.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire [1:0]         opcode_i,
  output logic              in_ready_o,
  input  lat_pkg::status_t  status_i,
  output lat_pkg::cmd_e     cmd_o
);

  lat_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lat_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = lat_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      lat_pkg::ST_CLEAR: begin
        cmd_o = lat_pkg::CMD_CLEAR;
        if (status_i.clr_last) state_d = lat_pkg::ST_IDLE;
      end
      lat_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = lat_pkg::CMD_CAPTURE;
          unique case (lat_pkg::opcode_e'(opcode_i))
            lat_pkg::OP_LOAD:  state_d = lat_pkg::ST_LOAD;
            lat_pkg::OP_MOVE:  state_d = lat_pkg::ST_MV_SCAN;
            lat_pkg::OP_QUERY: state_d = lat_pkg::ST_Q_SCAN;
            default:           state_d = lat_pkg::ST_RESULT;
          endcase
        end
      end
      lat_pkg::ST_LOAD: begin
        cmd_o   = lat_pkg::CMD_LOAD;
        state_d = lat_pkg::ST_RESULT;
      end
      lat_pkg::ST_MV_SCAN: begin
        cmd_o = lat_pkg::CMD_SCAN;
        if (status_i.hit || status_i.scan_end) state_d = lat_pkg::ST_MV_SRC;
      end
      lat_pkg::ST_MV_SRC: begin
        cmd_o   = lat_pkg::CMD_MV_SRC;
        state_d = lat_pkg::ST_MV_CLR;
      end
      lat_pkg::ST_MV_CLR: begin
        cmd_o   = lat_pkg::CMD_MV_CLR;
        state_d = lat_pkg::ST_MV_SET;
      end
      lat_pkg::ST_MV_SET: begin
        cmd_o   = lat_pkg::CMD_MV_SET;
        state_d = lat_pkg::ST_RESULT;
      end
      lat_pkg::ST_Q_SCAN: begin
        cmd_o = lat_pkg::CMD_QSCAN;
        if (status_i.total_zero) begin
          state_d = lat_pkg::ST_RESULT;
        end else if (status_i.q_done) begin
          state_d = lat_pkg::ST_Q_INIT;
        end
      end
      lat_pkg::ST_Q_INIT: begin
        cmd_o   = lat_pkg::CMD_DIV_INIT;
        state_d = lat_pkg::ST_Q_DIV;
      end
      lat_pkg::ST_Q_DIV: begin
        cmd_o = lat_pkg::CMD_DIV_STEP;
        if (status_i.div_last) state_d = lat_pkg::ST_RESULT;
      end
      lat_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o   = lat_pkg::CMD_RESULT;
          state_d = lat_pkg::ST_IDLE;
        end
      end
      default: state_d = lat_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lat_dpath.sv =====
// ----------------------------------------------------------------------------
// lat_dpath
// Occupancy and atom memories, scan counter, square-sum pipe, serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_dpath #(
  parameter int unsigned MAX_SITES = 4096,
  parameter int unsigned MAX_ATOMS = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  lat_pkg::cmd_e                      cmd_i,
  output lat_pkg::status_t                   status_o,
  input  wire                                cfg_we_i,
  input  wire [lat_pkg::LIM_W-1:0]           cfg_wdata_i,
  input  wire [1:0]                          opcode_i,
  input  wire [lat_pkg::SITE_W-1:0]          site_i,
  input  wire                                site_filled_i,
  input  wire [lat_pkg::SITE_W-1:0]          dest_site_i,
  input  wire signed [lat_pkg::STEP_W-1:0]   step_x_i,
  input  wire signed [lat_pkg::STEP_W-1:0]   step_y_i,
  input  wire signed [lat_pkg::STEP_W-1:0]   step_z_i,
  input  wire                                m_tready_i,
  output logic                               m_tvalid_o,
  output logic                               empty_source_o,
  output logic                               atom_missing_o,
  output logic [lat_pkg::MSD_W-1:0]          mean_sq_disp_o,
  output logic [lat_pkg::HELD_W-1:0]         atoms_held_o
);

  localparam int unsigned SAW   = $clog2(MAX_SITES);
  localparam int unsigned CW    = $clog2(MAX_ATOMS + 1);
  localparam int unsigned AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned ACC_W = lat_pkg::MSD_W + CW;
  localparam int unsigned SW    = lat_pkg::STEP_W;

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] s);
    return s[SW-1] ? (~s + 1'b1) : s;
  endfunction

  // item registers
  lat_pkg::opcode_e                 op_q;
  logic [lat_pkg::SITE_W-1:0]       site_q, dest_q;
  logic                             filled_q;
  logic signed [SW-1:0]             stx_q, sty_q, stz_q;
  logic [lat_pkg::LIM_W-1:0]        lim_q;

  // control
  logic [SAW-1:0] clr_idx_q;
  logic [CW-1:0]  total_q, idx_q;
  logic [AW-1:0]  rd_addr_q, who_q;
  logic           rdv_q, v1_q, v2_q, missing_q, empty_q, sat_q, out_valid_q;
  logic [lat_pkg::CNT6_W-1:0] cnt_q;

  // datapath payload
  logic [lat_pkg::MSD_W-1:0] sqx_q, sqy_q, sqz_q, term_q, quo_q;
  logic [ACC_W-1:0]          acc_q;
  logic [CW-1:0]             rem_q;

  // memories
  logic          occ_mem [MAX_SITES];
  logic          occ_rd_q;
  lat_pkg::atom_t atom_mem [MAX_ATOMS];
  lat_pkg::atom_t atom_rd_q;

  logic [31:0]   site_w, dest_w;
  logic [SAW-1:0] src_idx, dst_idx;
  logic          src_ok, dest_ok, scan_rd, append, upd;

  assign site_w  = 32'(site_q);
  assign dest_w  = 32'(dest_q);
  assign src_idx = site_w[SAW-1:0];
  assign dst_idx = dest_w[SAW-1:0];
  assign src_ok  = ({1'b0, site_q} < lim_q) && (site_w < 32'(MAX_SITES));
  assign dest_ok = ({1'b0, dest_q} < lim_q) && (dest_w < 32'(MAX_SITES));

  assign scan_rd = ((cmd_i == lat_pkg::CMD_SCAN) || (cmd_i == lat_pkg::CMD_QSCAN))
                   && (idx_q < total_q);
  assign append  = (cmd_i == lat_pkg::CMD_LOAD) && src_ok && filled_q
                   && (total_q < CW'(MAX_ATOMS));
  assign upd     = (cmd_i == lat_pkg::CMD_MV_CLR) && (total_q != '0);

  // ---- occupancy memory: one write, one registered read ----
  logic           occ_we, occ_wd;
  logic [SAW-1:0] occ_wa;

  always_comb begin
    occ_we = 1'b0;
    occ_wa = src_idx;
    occ_wd = 1'b0;
    case (cmd_i)
      lat_pkg::CMD_CLEAR: begin
        occ_we = 1'b1;
        occ_wa = clr_idx_q;
      end
      lat_pkg::CMD_LOAD: begin
        occ_we = src_ok;
        occ_wd = filled_q;
      end
      lat_pkg::CMD_MV_CLR: occ_we = src_ok;
      lat_pkg::CMD_MV_SET: begin
        occ_we = dest_ok;
        occ_wa = dst_idx;
        occ_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    if (cmd_i == lat_pkg::CMD_MV_SRC) occ_rd_q <= occ_mem[src_idx];
  end

  // ---- atom table: one write, one registered read ----
  logic           at_we, at_re;
  logic [AW-1:0]  at_wa, at_ra;
  lat_pkg::atom_t at_wd;
  logic [CW-1:0]  tot_w;

  assign tot_w = total_q;

  always_comb begin
    at_we = append || upd;
    at_wa = append ? tot_w[AW-1:0] : who_q;
    if (append) begin
      at_wd = '{site: site_q, sx: '0, sy: '0, sz: '0};
    end else begin
      at_wd = '{site: dest_q,
                sx: sat_add(atom_rd_q.sx, stx_q),
                sy: sat_add(atom_rd_q.sy, sty_q),
                sz: sat_add(atom_rd_q.sz, stz_q)};
    end
    at_re = scan_rd || (cmd_i == lat_pkg::CMD_MV_SRC);
    at_ra = scan_rd ? idx_q[AW-1:0] : who_q;
  end

  always_ff @(posedge clk_i) begin
    if (at_we) atom_mem[at_wa] <= at_wd;
    if (at_re) atom_rd_q <= atom_mem[at_ra];
  end

  // ---- status ----
  logic hit, scan_end;
  assign hit      = rdv_q && (atom_rd_q.site == site_q);
  assign scan_end = !rdv_q && (idx_q == total_q);

  always_comb begin
    status_o.clr_last   = (32'(clr_idx_q) == (MAX_SITES - 1));
    status_o.total_zero = (total_q == '0);
    status_o.hit        = hit;
    status_o.scan_end   = scan_end;
    status_o.q_done     = scan_end && !v1_q && !v2_q;
    status_o.div_last   = (cnt_q == lat_pkg::DIV_LAST);
    status_o.out_free   = !out_valid_q || m_tready_i;
  end

  // ---- configuration and item capture ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= lat_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == lat_pkg::CMD_CAPTURE) begin
      op_q     <= lat_pkg::opcode_e'(opcode_i);
      site_q   <= site_i;
      filled_q <= site_filled_i;
      dest_q   <= dest_site_i;
      stx_q    <= step_x_i;
      sty_q    <= step_y_i;
      stz_q    <= step_z_i;
    end
  end

  // ---- control registers ----
  logic [CW:0] rem2;
  logic        ge;
  logic [CW-1:0] hi;

  assign hi   = acc_q[ACC_W-1:lat_pkg::MSD_W];
  assign rem2 = {rem_q, quo_q[lat_pkg::MSD_W-1]};
  assign ge   = rem2 >= {1'b0, total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      rd_addr_q   <= '0;
      who_q       <= '0;
      rdv_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      missing_q   <= 1'b0;
      empty_q     <= 1'b0;
      sat_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rdv_q <= scan_rd;
      v1_q  <= rdv_q && (cmd_i == lat_pkg::CMD_QSCAN);
      v2_q  <= v1_q;
      if (scan_rd) begin
        idx_q     <= idx_q + 1'b1;
        rd_addr_q <= idx_q[AW-1:0];
      end
      if (append) total_q <= total_q + 1'b1;
      case (cmd_i)
        lat_pkg::CMD_CLEAR: clr_idx_q <= clr_idx_q + 1'b1;
        lat_pkg::CMD_CAPTURE: begin
          idx_q     <= '0;
          missing_q <= 1'b0;
          empty_q   <= 1'b0;
        end
        lat_pkg::CMD_SCAN: begin
          if (hit) begin
            who_q     <= rd_addr_q;
            missing_q <= 1'b0;
          end else if (scan_end) begin
            who_q     <= '0;
            missing_q <= 1'b1;
          end
        end
        lat_pkg::CMD_MV_CLR: empty_q <= src_ok ? !occ_rd_q : 1'b1;
        lat_pkg::CMD_DIV_INIT: begin
          sat_q <= (hi >= total_q);
          cnt_q <= '0;
        end
        lat_pkg::CMD_DIV_STEP: cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
      if (cmd_i == lat_pkg::CMD_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- square-sum pipe and restoring divider ----
  always_ff @(posedge clk_i) begin
    sqx_q  <= 64'(mag(atom_rd_q.sx)) * 64'(mag(atom_rd_q.sx));
    sqy_q  <= 64'(mag(atom_rd_q.sy)) * 64'(mag(atom_rd_q.sy));
    sqz_q  <= 64'(mag(atom_rd_q.sz)) * 64'(mag(atom_rd_q.sz));
    term_q <= sqx_q + sqy_q + sqz_q;
    if (cmd_i == lat_pkg::CMD_CAPTURE) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(term_q);
    end
    if (cmd_i == lat_pkg::CMD_DIV_INIT) begin
      rem_q <= (hi >= total_q) ? '0 : hi;
      quo_q <= acc_q[lat_pkg::MSD_W-1:0];
    end else if (cmd_i == lat_pkg::CMD_DIV_STEP) begin
      rem_q <= ge ? CW'(rem2 - {1'b0, total_q}) : rem2[CW-1:0];
      quo_q <= {quo_q[lat_pkg::MSD_W-2:0], ge};
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i) begin
    if (cmd_i == lat_pkg::CMD_RESULT) begin
      empty_source_o <= (op_q == lat_pkg::OP_MOVE) && empty_q;
      atom_missing_o <= (op_q == lat_pkg::OP_MOVE) && missing_q;
      if ((op_q == lat_pkg::OP_QUERY) && (total_q != '0)) begin
        mean_sq_disp_o <= sat_q ? '1 : quo_q;
      end else begin
        mean_sq_disp_o <= '0;
      end
      atoms_held_o <= lat_pkg::HELD_W'(total_q);
    end
  end

  assign m_tvalid_o = out_valid_q;

  // ---- assertions ----
  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == lat_pkg::CMD_RESULT) |-> (!out_valid_q || m_tready_i))
    else $error("result loaded over an untaken transfer");

  a_total_grows_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> (total_q == CW'($past(total_q) + 1'b1)))
    else $error("atom count jumped");

  a_div_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == lat_pkg::CMD_DIV_STEP) |-> (rem_q < total_q))
    else $error("divider remainder out of range");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    append |-> (32'(total_q) < MAX_ATOMS))
    else $error("append past table end");

endmodule

`default_nettype wire

// ===== rtl/lattice_atom_tracker.sv =====
// ----------------------------------------------------------------------------
// lattice_atom_tracker
// Site occupancy and atom displacement tracker for lattice hop simulations.
// ----------------------------------------------------------------------------
// After reset the block sweeps the occupancy memory to zero, one site per
// clock, so s_axis_tready stays low until the sweep ends (config writes are
// taken during the sweep). It then handles one item at a time and returns
// exactly one result transfer per input transfer. A move walks the atom
// table one entry per clock until the first atom on the old site, then
// reads, clears and sets the occupancy bits and updates the saturating
// Q16.16 sums. A query streams every atom through the squaring pipe and
// then runs a one-bit-per-clock restoring divider. The single-port atom
// table read paces the move and query scans. A finished result sits in
// the output register, so the next item is taken while it waits.
`default_nettype none

module lattice_atom_tracker #(
  parameter int unsigned MAX_SITES = 4096,
  parameter int unsigned MAX_ATOMS = 4096
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // config: lattice_sites
  input  wire          cfg_we_i,
  input  wire [12:0]   cfg_wdata_i,
  // input stream
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire [127:0]  s_axis_tdata,  // site[11:0], site_filled[12], dest_site[24:13],
                                      // step_x[56:25], step_y[88:57], step_z[120:89]
  input  wire [1:0]    s_axis_tuser,  // opcode[1:0]
  // result stream
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [79:0]  m_axis_tdata   // empty_source[0], atom_missing[1],
                                      // mean_sq_disp[65:2], atoms_held[78:66]
);

  lat_pkg::cmd_e    cmd;
  lat_pkg::status_t status;

  logic                       empty_source, atom_missing;
  logic [lat_pkg::MSD_W-1:0]  mean_sq_disp;
  logic [lat_pkg::HELD_W-1:0] atoms_held;

  lat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lat_dpath #(
    .MAX_SITES (MAX_SITES),
    .MAX_ATOMS (MAX_ATOMS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (s_axis_tuser),
    .site_i         (s_axis_tdata[11:0]),
    .site_filled_i  (s_axis_tdata[12]),
    .dest_site_i    (s_axis_tdata[24:13]),
    .step_x_i       (s_axis_tdata[56:25]),
    .step_y_i       (s_axis_tdata[88:57]),
    .step_z_i       (s_axis_tdata[120:89]),
    .m_tready_i     (m_axis_tready),
    .m_tvalid_o     (m_axis_tvalid),
    .empty_source_o (empty_source),
    .atom_missing_o (atom_missing),
    .mean_sq_disp_o (mean_sq_disp),
    .atoms_held_o   (atoms_held)
  );

  // pack result, zero pad to whole bytes
  assign m_axis_tdata = {1'b0, atoms_held, mean_sq_disp, atom_missing, empty_source};

endmodule

`default_nettype wire
